@@ sv/acst_pkg.sv @@
`timescale 1ns / 1ps
// acst_pkg: sizes, codes and item types of the active command slot table.
// Used by active_command_slot_table; depends on nothing.
package acst_pkg;

  localparam int SLOTS        = 16;
  localparam int COMMAND_BITS = 16;

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam int KIND_W    = 2;
  localparam int CMD_IN_W  = 16;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 4;
  localparam int CFG_W     = 5;

  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RESET = 5'd16;

  localparam logic [KIND_W-1:0] KIND_STORE     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY_ONE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_QUERY_ALL = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [CMD_IN_W-1:0] command;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                finished;
    logic [SLOT_W-1:0]   slot;
  } out_item_t;

endpackage

@@ sv/active_command_slot_table.sv @@
`timescale 1ns / 1ps
// active_command_slot_table: table of active command numbers with a serial
// slot scanner. Depends on acst_pkg for sizes, codes and item types.

// One item is taken at a time. After acceptance a single shared compare
// unit walks the slots from slot 0, one slot per cycle, and stops at the
// first hit or after slots_in_use slots (capped at SLOTS). An item is
// accepted in the idle state, scanned in the scan state, and its result
// is loaded in the push state, which waits while an older result is not
// yet taken. The next item can be accepted as soon as the result is
// loaded, while it still waits to be taken. The table is empty after
// reset; no clearing pass is needed. The configuration port is always
// ready and must be written only while the block is idle.
module active_command_slot_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  acst_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output acst_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [acst_pkg::CFG_W-1:0]    cfg_slots_in_use
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;

  logic [1:0]                          state_r, state_nxt;
  logic [acst_pkg::CNT_W-1:0]          idx_r, idx_nxt;
  logic [acst_pkg::KIND_W-1:0]         kind_r;
  logic [acst_pkg::COMMAND_BITS-1:0]   cmd_r;
  acst_pkg::out_item_t                 res_r, res_nxt;
  acst_pkg::out_item_t                 out_r;
  logic                                out_valid_r, out_valid_nxt;
  logic [acst_pkg::CFG_W-1:0]          slots_in_use_r;
  logic [acst_pkg::SLOTS-1:0]          valid_r;
  logic [acst_pkg::COMMAND_BITS-1:0]   slot_cmd_r [acst_pkg::SLOTS];

  logic [acst_pkg::CNT_W-1:0]          lim;
  logic [acst_pkg::IDX_W-1:0]          idx;
  logic [31:0]                         idx_ext;
  logic [31:0]                         cmd_ext;
  logic                                cur_valid;
  logic                                cur_match;
  logic                                hit;
  logic                                at_end;
  logic                                set_valid;
  logic                                clr_valid;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign cmd_ext = {16'd0, in_item.command};
  assign idx     = idx_r[acst_pkg::IDX_W-1:0];
  assign idx_ext = 32'(idx);

  always_comb begin
    if (32'(slots_in_use_r) > 32'(acst_pkg::SLOTS)) begin
      lim = acst_pkg::CNT_W'(acst_pkg::SLOTS);
    end else begin
      lim = acst_pkg::CNT_W'(slots_in_use_r);
    end
  end

  // shared compare unit: one slot per cycle
  assign at_end    = (idx_r >= lim);
  assign cur_valid = valid_r[idx];
  assign cur_match = (slot_cmd_r[idx] == cmd_r);

  always_comb begin
    case (kind_r)
      acst_pkg::KIND_STORE:     hit = !cur_valid;
      acst_pkg::KIND_DELETE:    hit = cur_valid && cur_match;
      acst_pkg::KIND_QUERY_ONE: hit = cur_valid && cur_match;
      acst_pkg::KIND_QUERY_ALL: hit = cur_valid;
      default:                  hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    set_valid     = 1'b0;
    clr_valid     = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SCAN;
          idx_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (at_end) begin
          state_nxt = ST_PUSH;
          res_nxt   = '0;
          case (kind_r)
            acst_pkg::KIND_STORE:  res_nxt.status = acst_pkg::ST_FULL;
            acst_pkg::KIND_DELETE: res_nxt.status = acst_pkg::ST_NOT_FOUND;
            default:               res_nxt.finished = 1'b1;
          endcase
        end else if (hit) begin
          state_nxt = ST_PUSH;
          res_nxt   = '0;
          case (kind_r)
            acst_pkg::KIND_STORE: begin
              set_valid    = 1'b1;
              res_nxt.slot = idx_ext[acst_pkg::SLOT_W-1:0];
            end
            acst_pkg::KIND_DELETE: begin
              clr_valid    = 1'b1;
              res_nxt.slot = idx_ext[acst_pkg::SLOT_W-1:0];
            end
            default: res_nxt.finished = 1'b0;
          endcase
        end else begin
          idx_nxt = idx_r + acst_pkg::CNT_W'(1);
        end
      end
      ST_PUSH: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
      valid_r        <= '0;
      slots_in_use_r <= acst_pkg::SLOTS_IN_USE_RESET;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        slots_in_use_r <= cfg_slots_in_use;
      end
      if (set_valid) begin
        valid_r[idx] <= 1'b1;
      end else if (clr_valid) begin
        valid_r[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_valid && in_ready) begin
      kind_r <= in_item.kind;
      cmd_r  <= cmd_ext[acst_pkg::COMMAND_BITS-1:0];
    end
    if (set_valid) begin
      slot_cmd_r[idx] <= cmd_r;
    end
    if (state_r == ST_PUSH && (!out_valid_r || out_ready)) begin
      out_r <= res_r;
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == ST_SCAN && idx_r == '0)
    else $error("accepted item did not start a scan at slot 0");

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SCAN |-> idx_r <= lim)
    else $error("scan index ran past the slot limit");

  a_table_only_changes_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_SCAN |=> valid_r == $past(valid_r))
    else $error("slot valid bits changed outside a scan");

  a_one_slot_per_item: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> ($countones(valid_r ^ $past(valid_r)) <= 1))
    else $error("more than one slot changed in a cycle");

  a_result_from_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_PUSH)
    else $error("result presented without a finished scan");
`endif

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: self-checking bench for active_command_slot_table.
// Directed and random store/delete/query items with random stalls on both
// sides; results are predicted in-line. Depends on acst_pkg and the RTL.
module tb_top;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * acst_pkg::SLOTS + 8;
  localparam int RANDOM_ITEMS   = 1000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  acst_pkg::in_item_t            in_item = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  acst_pkg::out_item_t           out_item;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [acst_pkg::CFG_W-1:0]    cfg_slots_in_use = '0;

  acst_pkg::in_item_t                pending_items[$];
  acst_pkg::out_item_t               expected_results[$];
  acst_pkg::out_item_t               oldest;
  logic                              tbl_valid [acst_pkg::SLOTS];
  logic [acst_pkg::COMMAND_BITS-1:0] tbl_cmd [acst_pkg::SLOTS];
  logic [acst_pkg::CFG_W-1:0]        active_slots = acst_pkg::SLOTS_IN_USE_RESET;
  logic [acst_pkg::CMD_IN_W-1:0]     cmd_pool [8];

  int items_queued = 0;
  int items_taken  = 0;
  int cfg_writes   = 0;
  int stall_cycles = 0;
  int errors       = 0;
  int in_wait      = 0;
  int out_wait     = 0;
  bit in_taken     = 1'b0;
  bit out_taken    = 1'b0;
  bit in_idle      = 1'b1;
  bit out_idle     = 1'b1;

  active_command_slot_table dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_item         (out_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_slots_in_use (cfg_slots_in_use)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Updates the shadow table and returns the response the item must get.
  function automatic acst_pkg::out_item_t table_response(acst_pkg::in_item_t it);
    acst_pkg::out_item_t               r;
    int                                lim;
    int                                i;
    bit                                hit;
    logic [acst_pkg::COMMAND_BITS-1:0] cmd;
    r = '0;
    hit = 1'b0;
    cmd = it.command[acst_pkg::COMMAND_BITS-1:0];
    lim = (active_slots > acst_pkg::SLOTS) ? acst_pkg::SLOTS : int'(active_slots);
    case (it.kind)
      acst_pkg::KIND_STORE: begin
        r.status = acst_pkg::ST_FULL;
        for (i = 0; i < lim && !hit; i++) begin
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1'b1;
            tbl_cmd[i] = cmd;
            r.status = acst_pkg::ST_OK;
            r.slot = acst_pkg::SLOT_W'(i);
            hit = 1'b1;
          end
        end
      end
      acst_pkg::KIND_DELETE: begin
        r.status = acst_pkg::ST_NOT_FOUND;
        for (i = 0; i < lim && !hit; i++) begin
          if (tbl_valid[i] && tbl_cmd[i] == cmd) begin
            tbl_valid[i] = 1'b0;
            r.status = acst_pkg::ST_OK;
            r.slot = acst_pkg::SLOT_W'(i);
            hit = 1'b1;
          end
        end
      end
      acst_pkg::KIND_QUERY_ONE: begin
        for (i = 0; i < lim; i++)
          if (tbl_valid[i] && tbl_cmd[i] == cmd) hit = 1'b1;
        r.finished = !hit;
      end
      acst_pkg::KIND_QUERY_ALL: begin
        for (i = 0; i < lim; i++)
          if (tbl_valid[i]) hit = 1'b1;
        r.finished = !hit;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Handshake sampling, prediction and checking.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status %0d finished %0d slot %0d",
                   $time, out_item.status, out_item.finished, out_item.slot);
          errors++;
        end else begin
          oldest = expected_results.pop_front();
          if (out_item.status !== oldest.status) begin
            $display("%0t: status expected %0d, actual %0d",
                     $time, oldest.status, out_item.status);
            errors++;
          end
          if (out_item.finished !== oldest.finished) begin
            $display("%0t: finished expected %0d, actual %0d",
                     $time, oldest.finished, out_item.finished);
            errors++;
          end
          if (out_item.slot !== oldest.slot) begin
            $display("%0t: slot expected %0d, actual %0d",
                     $time, oldest.slot, out_item.slot);
            errors++;
          end
        end
      end
      if (in_valid && in_ready) begin
        expected_results.push_back(table_response(in_item));
        items_taken++;
        in_taken = 1'b1;
      end
      if (cfg_valid && cfg_ready) begin
        active_slots = cfg_slots_in_use;
        cfg_writes++;
      end
      if ((out_valid && out_ready) || (in_valid && in_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Item driver.
  always @(negedge clk) begin
    if (rst_n && !(in_valid && !in_taken)) begin
      if (in_taken) begin
        in_taken = 1'b0;
        in_wait = in_idle ? $urandom_range(0, 15) : 0;
      end
      if (in_wait != 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (pending_items.size() != 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side backpressure.
  always @(negedge clk) begin
    if (out_taken) begin
      out_taken = 1'b0;
      out_wait = out_idle ? $urandom_range(0, 15) : 0;
    end
    if (out_wait != 0) begin
      out_wait--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(negedge clk);
    $display("%0t: watchdog, no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic queue_item(input logic [acst_pkg::KIND_W-1:0] kind,
                            input logic [acst_pkg::CMD_IN_W-1:0] cmd);
    acst_pkg::in_item_t it;
    it.kind = kind;
    it.command = cmd;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Waits until every queued item has been taken and answered.
  task automatic settle();
    while (items_taken != items_queued || expected_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_slot_count(input logic [acst_pkg::CFG_W-1:0] n);
    int seen;
    seen = cfg_writes;
    @(negedge clk);
    cfg_slots_in_use <= n;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (cfg_writes == seen) @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int                            phase;
    int                            random_sent;
    int                            n;
    int                            store_weight;
    int                            r;
    logic [acst_pkg::KIND_W-1:0]   kind;
    logic [acst_pkg::CFG_W-1:0]    count;
    logic [acst_pkg::CMD_IN_W-1:0] cmd;

    for (int i = 0; i < acst_pkg::SLOTS; i++) tbl_valid[i] = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // empty table at reset count, duplicates, lowest-slot delete
    queue_item(acst_pkg::KIND_QUERY_ALL, 16'h0000);
    queue_item(acst_pkg::KIND_QUERY_ONE, 16'h0000);
    queue_item(acst_pkg::KIND_DELETE, 16'hFFFF);
    queue_item(acst_pkg::KIND_STORE, 16'h0000);
    queue_item(acst_pkg::KIND_STORE, 16'hFFFF);
    queue_item(acst_pkg::KIND_STORE, 16'hFFFF);
    queue_item(acst_pkg::KIND_QUERY_ONE, 16'hFFFF);
    queue_item(acst_pkg::KIND_DELETE, 16'hFFFF);
    queue_item(acst_pkg::KIND_QUERY_ONE, 16'hFFFF);
    queue_item(acst_pkg::KIND_QUERY_ALL, 16'hAAAA);
    queue_item(acst_pkg::KIND_DELETE, 16'h0000);
    queue_item(acst_pkg::KIND_DELETE, 16'h0000);
    settle();

    // count lowered: full table, hidden slot untouched
    set_slot_count(5'd2);
    @(posedge clk);
    queue_item(acst_pkg::KIND_STORE, 16'h5555);
    queue_item(acst_pkg::KIND_STORE, 16'h0001);
    queue_item(acst_pkg::KIND_STORE, 16'h7FFF);
    queue_item(acst_pkg::KIND_DELETE, 16'hFFFF);
    queue_item(acst_pkg::KIND_QUERY_ONE, 16'hFFFF);
    settle();

    // zero slots in use
    set_slot_count(5'd0);
    @(posedge clk);
    queue_item(acst_pkg::KIND_STORE, 16'h8000);
    queue_item(acst_pkg::KIND_DELETE, 16'h5555);
    queue_item(acst_pkg::KIND_QUERY_ONE, 16'h5555);
    queue_item(acst_pkg::KIND_QUERY_ALL, 16'h0000);
    settle();

    // count above SLOTS saturates; hidden slot visible again
    set_slot_count(5'd31);
    @(posedge clk);
    queue_item(acst_pkg::KIND_QUERY_ONE, 16'hFFFF);
    queue_item(acst_pkg::KIND_QUERY_ALL, 16'hFFFF);
    queue_item(acst_pkg::KIND_DELETE, 16'hFFFF);
    settle();

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        count = 5'd1;
      end else begin
        case ($urandom_range(0, 7))
          0: count = 5'd0;
          1: count = acst_pkg::CFG_W'(acst_pkg::SLOTS);
          2: count = acst_pkg::CFG_W'($urandom_range(acst_pkg::SLOTS + 1, 31));
          default: count = acst_pkg::CFG_W'($urandom_range(1, acst_pkg::SLOTS));
        endcase
      end
      set_slot_count(count);
      in_idle = $urandom_range(0, 3) != 0;
      out_idle = $urandom_range(0, 3) != 0;
      store_weight = $urandom_range(20, 70);
      for (int i = 0; i < 8; i++) cmd_pool[i] = acst_pkg::CMD_IN_W'($urandom);
      n = $urandom_range(20, 80);
      @(posedge clk);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < store_weight)
          kind = acst_pkg::KIND_STORE;
        else if (r < store_weight + (100 - store_weight) / 2)
          kind = acst_pkg::KIND_DELETE;
        else if (r % 4 == 0)
          kind = acst_pkg::KIND_QUERY_ALL;
        else
          kind = acst_pkg::KIND_QUERY_ONE;
        if ($urandom_range(0, 3) == 0)
          cmd = acst_pkg::CMD_IN_W'($urandom);
        else
          cmd = cmd_pool[3'($urandom_range(0, 7))];
        queue_item(kind, cmd);
      end
      random_sent += n;
      phase++;
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0t: %0d errors, %0d results outstanding",
               $time, errors, expected_results.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/acst_pkg.sv
sv/active_command_slot_table.sv
bench/tb_top.sv
